// ===== hw/rtl/sfp_pkg.sv =====
// sfp_pkg: shared constants, types and codes for the sensor frame parser.
// Used by sfp_front, sfp_queue, sfp_back and sensor_frame_parser.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int FrameBytes = 32;
  localparam int NumWords   = 13;
  localparam int QueueDepth = 2;

  localparam logic [7:0] HdrFirst  = 8'h42;
  localparam logic [7:0] HdrSecond = 8'h4D;

  localparam logic [4:0] BodyStartPos = 5'd2;
  localparam logic [4:0] FirstWordPos = 5'd5;
  localparam logic [4:0] SumEndPos    = 5'(FrameBytes - 2);
  localparam logic [4:0] LastWordPos  = 5'(FrameBytes - 3);
  localparam logic [4:0] LastPos      = 5'(FrameBytes - 1);
  localparam logic [3:0] LastIdx      = 4'(NumWords - 1);

  localparam logic [15:0] HdrSum = 16'(HdrFirst) + 16'(HdrSecond);

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhHdr2 = 2'd1,
    PhBody = 2'd2
  } phase_e;

  typedef enum logic {
    StatGood = 1'b0,
    StatBad  = 1'b1
  } status_e;

  typedef struct packed {
    status_e status;
    logic    bank;
  } desc_t;

  typedef struct packed {
    logic        en;
    logic        bank;
    logic [3:0]  idx;
    logic [15:0] data;
  } wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

// ===== hw/rtl/sfp_front.sv =====
// sfp_front: header hunt, byte position tracking, checksum and word assembly.
// Writes words into the back end's two frame banks; depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_front import sfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output desc_t      push_desc_o,
  output wr_t        wr_o,
  input  rel_t       rel_i
);

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  hi_q, hi_d;
  logic        bank_q, bank_d;
  logic [1:0]  busy_q, busy_d;
  logic        acc;
  logic        body_acc;
  logic        frame_end;
  logic        good;
  logic [4:0]  word_off;

  assign in_ready_o = !busy_q[bank_q] && !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign body_acc   = acc && (phase_q == PhBody);
  assign frame_end  = body_acc && (pos_q == LastPos);
  assign good       = ({hi_q, rx_byte_i} == sum_q);
  assign word_off   = pos_q - FirstWordPos;

  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      unique case (phase_q)
        PhHunt: phase_d = (rx_byte_i == HdrFirst) ? PhHdr2 : PhHunt;
        PhHdr2: begin
          if (rx_byte_i == HdrSecond) begin
            phase_d = PhBody;
          end else if (rx_byte_i != HdrFirst) begin
            phase_d = PhHunt;
          end
        end
        PhBody: phase_d = (pos_q == LastPos) ? PhHunt : PhBody;
        default: phase_d = PhHunt;
      endcase
    end
  end

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    hi_d   = hi_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (acc && phase_q == PhHdr2 && rx_byte_i == HdrSecond) begin
      pos_d = BodyStartPos;
      sum_d = HdrSum;
    end
    if (body_acc) begin
      if (pos_q < SumEndPos) begin
        sum_d = sum_q + 16'(rx_byte_i);
      end
      if (!pos_q[0]) begin
        hi_d = rx_byte_i;
      end
      if (pos_q == LastPos) begin
        pos_d = '0;
        sum_d = '0;
        if (good) begin
          busy_d[bank_q] = 1'b1;
          bank_d         = !bank_q;
        end
      end else begin
        pos_d = pos_q + 5'd1;
      end
    end
  end

  always_comb begin
    wr_o.en            = body_acc && pos_q[0] && (pos_q >= FirstWordPos)
                         && (pos_q <= LastWordPos);
    wr_o.bank          = bank_q;
    wr_o.idx           = word_off[4:1];
    wr_o.data          = {hi_q, rx_byte_i};
    push_o             = frame_end;
    push_desc_o.status = good ? StatGood : StatBad;
    push_desc_o.bank   = bank_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      pos_q   <= '0;
      sum_q   <= '0;
      hi_q    <= '0;
      bank_q  <= 1'b0;
      busy_q  <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      hi_q    <= hi_d;
      bank_q  <= bank_d;
      busy_q  <= busy_d;
    end
  end

endmodule

// ===== hw/rtl/sfp_queue.sv =====
// sfp_queue: short FIFO of frame descriptors between front and back end.
// Depends on sfp_pkg for desc_t.
`timescale 1ns / 1ps

module sfp_queue import sfp_pkg::*; #(
  parameter int Depth = QueueDepth
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_desc_i,
  output logic  full_o,
  output logic  valid_o,
  output desc_t head_o,
  input  logic  pop_i
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(Depth - 1);

  desc_t           mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == LastSlot) ? '0 : wp_q + PtrW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == LastSlot) ? '0 : rp_q + PtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sfp_back.sv =====
// sfp_back: two-bank frame word store and result emitter with output register.
// Drains descriptors from sfp_queue; depends on sfp_pkg.
`timescale 1ns / 1ps

module sfp_back import sfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wr_t         wr_i,
  input  logic        q_valid_i,
  input  desc_t       q_head_i,
  output logic        pop_o,
  output rel_t        rel_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        frame_status_o,
  output logic        last_word_o
);

  logic [15:0] store_q [2][NumWords];
  logic [3:0]  cnt_q;
  logic        valid_q;
  logic [3:0]  idx_q;
  logic [15:0] val_q;
  logic        stat_q;
  logic        last_q;
  logic        load;
  logic        bad;
  logic        at_last;

  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign bad     = (q_head_i.status == StatBad);
  assign at_last = (cnt_q == LastIdx);
  assign pop_o   = load && (bad || at_last);

  always_comb begin
    rel_o.en   = load && !bad && at_last;
    rel_o.bank = q_head_i.bank;
  end

  assign out_valid_o    = valid_q;
  assign word_index_o   = idx_q;
  assign word_value_o   = val_q;
  assign frame_status_o = stat_q;
  assign last_word_o    = last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.bank][wr_i.idx] <= wr_i.data;
    end
    if (load) begin
      if (bad) begin
        idx_q  <= '0;
        val_q  <= '0;
        stat_q <= StatBad;
        last_q <= 1'b1;
      end else begin
        idx_q  <= cnt_q;
        val_q  <= store_q[q_head_i.bank][cnt_q];
        stat_q <= StatGood;
        last_q <= at_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
      if (load && !bad) begin
        cnt_q <= at_last ? '0 : cnt_q + 4'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/sensor_frame_parser.sv =====
// sensor_frame_parser: top level of the 32-byte sum-checked frame parser.
// Instantiates sfp_front, sfp_queue and sfp_back; depends on sfp_pkg.
//
//   port group   | dir | handshake              | payload
//   -------------+-----+------------------------+------------------------------------
//   byte in      | in  | in_valid_i / in_ready_o | rx_byte_i
//   word out     | out | out_valid_o/out_ready_i | word_index_o, word_value_o,
//                |     |                        | frame_status_o, last_word_o
//
// One byte per cycle is taken while in_ready_o is high; a good frame's 13 words leave one
// per cycle from the output register while out_ready_i is high, a bad frame yields one word.
// Two word banks let the next frame fill while the last one drains; in_ready_o
// drops only when the fill bank is still draining or the descriptor queue is full.
// Reset (rst_ni low) returns to header hunt with empty queue and no output word.
`timescale 1ns / 1ps

module sensor_frame_parser import sfp_pkg::*; #(
  parameter int QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  word_index_o,
  output logic [15:0] word_value_o,
  output logic        frame_status_o,
  output logic        last_word_o
);

  logic  q_full;
  logic  push;
  desc_t push_desc;
  wr_t   wr;
  rel_t  rel;
  logic  q_valid;
  desc_t q_head;
  logic  pop;

  sfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc),
    .wr_o        (wr),
    .rel_i       (rel)
  );

  sfp_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (q_head),
    .pop_i       (pop)
  );

  sfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .wr_i           (wr),
    .q_valid_i      (q_valid),
    .q_head_i       (q_head),
    .pop_o          (pop),
    .rel_o          (rel),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_index_o   (word_index_o),
    .word_value_o   (word_value_o),
    .frame_status_o (frame_status_o),
    .last_word_o    (last_word_o)
  );

endmodule

// ===== bench/sensor_frame_parser_test.sv =====
// sensor_frame_parser_test: self-checking bench for the 32-byte sum-checked frame parser.
// Drives directed table frames, then random traffic; checks each output word against the
// typed table words or a local parser model. Depends on sfp_pkg and sensor_frame_parser.
`timescale 1ns / 1ps

module sensor_frame_parser_test;
  import sfp_pkg::*;

  localparam int CycleLimit = 200000;

  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] value;
    status_e     status;
    logic        last;
  } word_t;

  typedef enum logic [1:0] {
    PreNone,
    PreDouble,
    PreBroken,
    PreNoise
  } prelude_e;

  typedef enum logic [2:0] {
    PatNone,
    PatZero,
    PatOnes,
    PatIncr,
    PatHeaders,
    PatRandom
  } pattern_e;

  typedef enum logic [1:0] {
    CksGood,
    CksBad,
    CksMax
  } check_e;

  typedef struct {
    prelude_e    pre;
    pattern_e    pat;
    check_e      cks;
    bit          typed;
    logic [15:0] value;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  word_index_o;
  logic [15:0] word_value_o;
  logic        frame_status_o;
  logic        last_word_o;

  sensor_frame_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .word_index_o  (word_index_o),
    .word_value_o  (word_value_o),
    .frame_status_o(frame_status_o),
    .last_word_o   (last_word_o)
  );

  always #1 clk_i = ~clk_i;

  // parser model state
  phase_e      rx_phase = PhHunt;
  logic [4:0]  rx_pos = '0;
  logic [15:0] rx_sum = '0;
  logic [7:0]  rx_high = '0;
  logic [15:0] rx_words [NumWords];
  word_t       fresh [NumWords];

  word_t       expected_q [$];
  word_t       typed_q [$];
  logic [7:0]  byte_q [$];
  row_t        directed_rows [3];

  int send_idle = 0;
  int recv_idle = 0;
  int hold_len = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int bytes_sent = 0;

  function automatic int parse_byte(input logic [7:0] b);
    int          n;
    logic [15:0] cks;
    n = 0;
    case (rx_phase)
      PhHdr2: begin
        if (b == HdrSecond) begin
          rx_phase = PhBody;
          rx_pos   = BodyStartPos;
          rx_sum   = HdrSum;
        end else if (b != HdrFirst) begin
          rx_phase = PhHunt;
        end
      end
      PhBody: begin
        if (rx_pos < SumEndPos) rx_sum = rx_sum + 16'(b);
        if (!rx_pos[0]) begin
          rx_high = b;
        end else if (rx_pos >= FirstWordPos && rx_pos <= LastWordPos) begin
          rx_words[4'((rx_pos - FirstWordPos) >> 1)] = {rx_high, b};
        end
        if (rx_pos != LastPos) begin
          rx_pos = rx_pos + 5'd1;
        end else begin
          rx_phase = PhHunt;
          rx_pos   = '0;
          cks      = {rx_high, b};
          if (cks != rx_sum) begin
            fresh[0] = '{4'd0, 16'd0, StatBad, 1'b1};
            n = 1;
          end else begin
            for (int k = 0; k < NumWords; k++)
              fresh[k] = '{4'(k), rx_words[k], StatGood, 4'(k) == LastIdx};
            n = NumWords;
          end
          rx_sum = '0;
        end
      end
      default: rx_phase = (b == HdrFirst) ? PhHdr2 : PhHunt;
    endcase
    return n;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int n;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
    n = parse_byte(b);
    if (n > 0) begin
      if (typed_q.size() != 0) begin
        foreach (typed_q[i]) expected_q.push_back(typed_q[i]);
        typed_q.delete();
      end else begin
        for (int k = 0; k < n; k++) expected_q.push_back(fresh[k]);
      end
    end
  endtask

  task automatic flush_bytes();
    while (byte_q.size() != 0) send_byte(byte_q.pop_front());
  endtask

  task automatic build_frame(input prelude_e pre, input pattern_e pat, input check_e cks);
    logic [7:0]  body [FrameBytes];
    logic [7:0]  b;
    logic [15:0] sum;
    case (pre)
      PreDouble: byte_q.push_back(HdrFirst);
      PreBroken: begin
        byte_q.push_back(HdrFirst);
        b = 8'($urandom_range(0, 255));
        byte_q.push_back((b == HdrFirst || b == HdrSecond) ? 8'h00 : b);
      end
      PreNoise: begin
        repeat ($urandom_range(1, 4)) begin
          b = 8'($urandom_range(0, 255));
          byte_q.push_back((b == HdrFirst) ? 8'h41 : b);
        end
      end
      default: ;
    endcase
    if (pat == PatNone) return;
    body[0] = HdrFirst;
    body[1] = HdrSecond;
    sum = HdrSum;
    for (int p = 2; p < FrameBytes - 2; p++) begin
      case (pat)
        PatZero:    body[p] = 8'h00;
        PatOnes:    body[p] = 8'hFF;
        PatIncr:    body[p] = 8'(p * 9);
        PatHeaders: body[p] = p[0] ? HdrSecond : HdrFirst;
        default:    body[p] = 8'($urandom_range(0, 255));
      endcase
      sum = sum + 16'(body[p]);
    end
    case (cks)
      CksBad:  sum = sum ^ 16'($urandom_range(1, 65535));
      CksMax:  sum = 16'hFFFF;
      default: ;
    endcase
    body[FrameBytes-2] = sum[15:8];
    body[FrameBytes-1] = sum[7:0];
    foreach (body[p]) byte_q.push_back(body[p]);
  endtask

  task automatic run_row(input row_t row);
    word_t w;
    if (row.typed) begin
      if (row.cks == CksGood) begin
        for (int k = 0; k < NumWords; k++) begin
          w = '{4'(k), row.value, StatGood, 4'(k) == LastIdx};
          typed_q.push_back(w);
        end
      end else begin
        w = '{4'd0, 16'd0, StatBad, 1'b1};
        typed_q.push_back(w);
      end
    end
    build_frame(row.pre, row.pat, row.cks);
    flush_bytes();
  endtask

  task automatic random_item();
    int       r;
    prelude_e pre;
    pattern_e pat;
    check_e   cks;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      case ($urandom_range(0, 5))
        3:       pre = PreDouble;
        4:       pre = PreBroken;
        5:       pre = PreNoise;
        default: pre = PreNone;
      endcase
      case ($urandom_range(0, 9))
        0:       pat = PatZero;
        1:       pat = PatOnes;
        2:       pat = PatIncr;
        3:       pat = PatHeaders;
        default: pat = PatRandom;
      endcase
      case ($urandom_range(0, 9))
        8:       cks = CksBad;
        9:       cks = CksMax;
        default: cks = CksGood;
      endcase
      build_frame(pre, pat, cks);
    end else if (r < 93) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0:       b = HdrFirst;
          1:       b = HdrSecond;
          default: b = 8'($urandom_range(0, 255));
        endcase
        byte_q.push_back(b);
      end
    end else begin
      byte_q.push_back(HdrFirst);
      byte_q.push_back(HdrSecond);
      repeat ($urandom_range(1, 12)) byte_q.push_back(8'($urandom_range(0, 255)));
    end
    flush_bytes();
  endtask

  task automatic random_burst(input int count);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < count) random_item();
  endtask

  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_len > 0) begin
        hold = hold_len;
        hold_len = 0;
        out_ready_i <= 1'b0;
        while (hold > 0) begin
          @(posedge clk_i);
          hold--;
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin : check_word
    word_t got;
    word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{word_index_o, word_value_o, status_e'(frame_status_o), last_word_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word idx=%0d value=%h status=%0d last=%0b",
                 $time, got.idx, got.value, got.status, got.last);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (got.idx !== want.idx || got.value !== want.value ||
            got.status !== want.status || got.last !== want.last) begin
          $display("%0t: mismatch expected idx=%0d value=%h status=%0d last=%0b",
                   $time, want.idx, want.value, want.status, want.last);
          $display("%0t:          actual   idx=%0d value=%h status=%0d last=%0b",
                   $time, got.idx, got.value, got.status, got.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sensor_frame_parser_test failed");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      '{PreNone,   PatOnes,    CksGood, 1'b1, 16'hFFFF},
      '{PreNone,   PatZero,    CksBad,  1'b1, 16'h0000},
      '{PreBroken, PatNone,    CksGood, 1'b0, 16'h0000}
    };
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hold the receiver off so a held good frame and a bad one fill the queue
    send_idle = 18;
    recv_idle = 49;
    hold_len = 200;
    foreach (directed_rows[i]) run_row(directed_rows[i]);

    send_idle = 49;
    recv_idle = 18;
    random_burst(40);

    send_idle = 0;
    recv_idle = 0;
    random_burst(40);
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("sensor_frame_parser_test passed");
    end else begin
      $display("sensor_frame_parser_test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_front.sv
hw/rtl/sfp_queue.sv
hw/rtl/sfp_back.sv
hw/rtl/sensor_frame_parser.sv
bench/sensor_frame_parser_test.sv
